// ===== hw/rtl/tqfr_pkg.sv =====
// Shared constants, types and codes of the two-queue frame replacer.
package tqfr_pkg;

    localparam int FRAMES   = 1024;
    localparam int FRAME_W  = $clog2(FRAMES);
    localparam int NODE_W   = FRAME_W + 1;
    localparam int OP_W     = 2;
    localparam int FIELD_W  = 10;
    localparam int TDATA_W  = 16;

    typedef logic [NODE_W-1:0]  node_t;
    typedef logic [FRAME_W-1:0] addr_t;

    localparam node_t NIL = NODE_W'(FRAMES);

    localparam logic [OP_W-1:0] OP_PIN    = 2'd0;
    localparam logic [OP_W-1:0] OP_UNPIN  = 2'd1;
    localparam logic [OP_W-1:0] OP_VICTIM = 2'd2;

    typedef struct packed {
        logic  tracked;
        logic  infreq;
        logic  pinned;
        node_t next;
        node_t prev;
    } entry_t;

    typedef struct packed {
        logic tracked;
        logic infreq;
        logic pinned;
        logic next;
        logic prev;
    } wen_t;

    typedef struct packed {
        addr_t  addr;
        wen_t   wen;
        entry_t wdata;
    } mem_req_t;

    typedef struct packed {
        logic               found;
        logic [FIELD_W-1:0] frame;
    } result_t;

endpackage

// ===== hw/rtl/tqfr_frame_ram.sv =====
// Per-frame state memories with registered read and a tracked-bit clearing pass.
module tqfr_frame_ram (
    input  logic               clk,
    input  logic               rst_n,
    input  tqfr_pkg::mem_req_t req,
    output tqfr_pkg::entry_t   rdata,
    output logic               busy
);

    logic                  tracked_mem [tqfr_pkg::FRAMES];
    logic                  infreq_mem  [tqfr_pkg::FRAMES];
    logic                  pinned_mem  [tqfr_pkg::FRAMES];
    tqfr_pkg::node_t       next_mem    [tqfr_pkg::FRAMES];
    tqfr_pkg::node_t       prev_mem    [tqfr_pkg::FRAMES];
    tqfr_pkg::node_t       clr_cnt_reg;
    tqfr_pkg::node_t       clr_cnt_next;
    tqfr_pkg::entry_t      rdata_reg;

    assign busy  = (clr_cnt_reg < tqfr_pkg::NIL);
    assign rdata = rdata_reg;

    always_comb
    begin
        clr_cnt_next = clr_cnt_reg;
        if (busy)
        begin
            clr_cnt_next = clr_cnt_reg + tqfr_pkg::node_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else
        begin
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy)
        begin
            tracked_mem[clr_cnt_reg[tqfr_pkg::FRAME_W-1:0]] <= 1'b0;
        end
        else if (req.wen.tracked)
        begin
            tracked_mem[req.addr] <= req.wdata.tracked;
        end
        if (req.wen.infreq)
        begin
            infreq_mem[req.addr] <= req.wdata.infreq;
        end
        if (req.wen.pinned)
        begin
            pinned_mem[req.addr] <= req.wdata.pinned;
        end
        if (req.wen.next)
        begin
            next_mem[req.addr] <= req.wdata.next;
        end
        if (req.wen.prev)
        begin
            prev_mem[req.addr] <= req.wdata.prev;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg.tracked <= tracked_mem[req.addr];
        rdata_reg.infreq  <= infreq_mem[req.addr];
        rdata_reg.pinned  <= pinned_mem[req.addr];
        rdata_reg.next    <= next_mem[req.addr];
        rdata_reg.prev    <= prev_mem[req.addr];
    end

endmodule

// ===== hw/rtl/tqfr_ctrl.sv =====
// Sequencer that walks and relinks the history and frequent lists through the frame memory.
module tqfr_ctrl (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [tqfr_pkg::OP_W-1:0]          in_opcode,
    input  logic [tqfr_pkg::FIELD_W-1:0]       in_frame,
    output logic                               res_valid,
    input  logic                               res_ready,
    output tqfr_pkg::result_t                  res,
    output tqfr_pkg::mem_req_t                 mem_req,
    input  tqfr_pkg::entry_t                   mem_rdata,
    input  logic                               mem_busy
);

    typedef enum logic [9:0] {
        S_CLEAR    = 10'b0000000001,
        S_IDLE     = 10'b0000000010,
        S_LOOK     = 10'b0000000100,
        S_VSEL     = 10'b0000001000,
        S_VLOOK    = 10'b0000010000,
        S_DET_P    = 10'b0000100000,
        S_DET_N    = 10'b0001000000,
        S_ATT      = 10'b0010000000,
        S_LINK_OLD = 10'b0100000000,
        S_DONE     = 10'b1000000000
    } state_t;

    state_t                      state_reg, state_next;
    logic [tqfr_pkg::OP_W-1:0]   op_reg, op_next;
    tqfr_pkg::node_t             cur_reg, cur_next;
    tqfr_pkg::node_t             p_reg, p_next;
    tqfr_pkg::node_t             n_reg, n_next;
    tqfr_pkg::node_t             old_reg, old_next;
    logic                        list_reg, list_next;
    tqfr_pkg::node_t             hh_reg, hh_next;
    tqfr_pkg::node_t             ht_reg, ht_next;
    tqfr_pkg::node_t             fh_reg, fh_next;
    tqfr_pkg::node_t             ft_reg, ft_next;
    tqfr_pkg::result_t           res_reg, res_next;
    tqfr_pkg::node_t             in_node;
    logic                        det_en;
    logic                        det_list;

    assign in_node   = tqfr_pkg::NODE_W'(in_frame);
    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        cur_next   = cur_reg;
        p_next     = p_reg;
        n_next     = n_reg;
        old_next   = old_reg;
        list_next  = list_reg;
        hh_next    = hh_reg;
        ht_next    = ht_reg;
        fh_next    = fh_reg;
        ft_next    = ft_reg;
        res_next   = res_reg;
        det_en     = 1'b0;
        det_list   = list_reg;
        mem_req    = '0;
        mem_req.addr = in_node[tqfr_pkg::FRAME_W-1:0];

        case (state_reg)
            S_CLEAR:
            begin
                if (!mem_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next  = in_opcode;
                    cur_next = in_node;
                    res_next = '0;
                    if (in_opcode == tqfr_pkg::OP_VICTIM)
                    begin
                        cur_next   = ht_reg;
                        list_next  = 1'b0;
                        state_next = S_VSEL;
                    end
                    else if ((in_opcode == tqfr_pkg::OP_PIN || in_opcode == tqfr_pkg::OP_UNPIN)
                             && in_node < tqfr_pkg::NIL)
                    begin
                        state_next = S_LOOK;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_LOOK:
            begin
                mem_req.addr = cur_reg[tqfr_pkg::FRAME_W-1:0];
                if (op_reg == tqfr_pkg::OP_PIN)
                begin
                    if (mem_rdata.tracked)
                    begin
                        mem_req.wen.pinned   = 1'b1;
                        mem_req.wdata.pinned = 1'b1;
                    end
                    state_next = S_DONE;
                end
                else if (!mem_rdata.tracked)
                begin
                    mem_req.wen         = '1;
                    mem_req.wdata.tracked = 1'b1;
                    mem_req.wdata.infreq  = 1'b0;
                    mem_req.wdata.pinned  = 1'b0;
                    mem_req.wdata.prev    = tqfr_pkg::NIL;
                    mem_req.wdata.next    = hh_reg;
                    hh_next = cur_reg;
                    if (hh_reg < tqfr_pkg::NIL)
                    begin
                        old_next   = hh_reg;
                        state_next = S_LINK_OLD;
                    end
                    else
                    begin
                        ht_next    = cur_reg;
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    p_next     = mem_rdata.prev;
                    n_next     = mem_rdata.next;
                    list_next  = mem_rdata.infreq;
                    det_en     = 1'b1;
                    det_list   = mem_rdata.infreq;
                    state_next = S_DET_P;
                end
            end
            S_VSEL:
            begin
                mem_req.addr = cur_reg[tqfr_pkg::FRAME_W-1:0];
                if (cur_reg < tqfr_pkg::NIL)
                begin
                    state_next = S_VLOOK;
                end
                else if (!list_reg)
                begin
                    cur_next  = ft_reg;
                    list_next = 1'b1;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_VLOOK:
            begin
                mem_req.addr = cur_reg[tqfr_pkg::FRAME_W-1:0];
                if (mem_rdata.pinned)
                begin
                    cur_next   = mem_rdata.prev;
                    state_next = S_VSEL;
                end
                else
                begin
                    mem_req.wen.tracked   = 1'b1;
                    mem_req.wdata.tracked = 1'b0;
                    p_next         = mem_rdata.prev;
                    n_next         = mem_rdata.next;
                    det_en         = 1'b1;
                    res_next.found = 1'b1;
                    res_next.frame = tqfr_pkg::FIELD_W'(cur_reg[tqfr_pkg::FRAME_W-1:0]);
                    state_next     = S_DET_P;
                end
            end
            S_DET_P:
            begin
                mem_req.addr = p_reg[tqfr_pkg::FRAME_W-1:0];
                if (p_reg < tqfr_pkg::NIL)
                begin
                    mem_req.wen.next   = 1'b1;
                    mem_req.wdata.next = n_reg;
                end
                state_next = S_DET_N;
            end
            S_DET_N:
            begin
                mem_req.addr = n_reg[tqfr_pkg::FRAME_W-1:0];
                if (n_reg < tqfr_pkg::NIL)
                begin
                    mem_req.wen.prev   = 1'b1;
                    mem_req.wdata.prev = p_reg;
                end
                state_next = (op_reg == tqfr_pkg::OP_UNPIN) ? S_ATT : S_DONE;
            end
            S_ATT:
            begin
                mem_req.addr          = cur_reg[tqfr_pkg::FRAME_W-1:0];
                mem_req.wen           = '1;
                mem_req.wdata.tracked = 1'b1;
                mem_req.wdata.infreq  = 1'b1;
                mem_req.wdata.pinned  = 1'b0;
                mem_req.wdata.prev    = tqfr_pkg::NIL;
                mem_req.wdata.next    = fh_reg;
                fh_next = cur_reg;
                if (fh_reg < tqfr_pkg::NIL)
                begin
                    old_next   = fh_reg;
                    state_next = S_LINK_OLD;
                end
                else
                begin
                    ft_next    = cur_reg;
                    state_next = S_DONE;
                end
            end
            S_LINK_OLD:
            begin
                mem_req.addr       = old_reg[tqfr_pkg::FRAME_W-1:0];
                mem_req.wen.prev   = 1'b1;
                mem_req.wdata.prev = cur_reg;
                state_next         = S_DONE;
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase

        // Unlinking a frame moves the list ends that pointed at it.
        if (det_en)
        begin
            if (!det_list)
            begin
                if (!(mem_rdata.prev < tqfr_pkg::NIL))
                begin
                    hh_next = mem_rdata.next;
                end
                if (!(mem_rdata.next < tqfr_pkg::NIL))
                begin
                    ht_next = mem_rdata.prev;
                end
            end
            else
            begin
                if (!(mem_rdata.prev < tqfr_pkg::NIL))
                begin
                    fh_next = mem_rdata.next;
                end
                if (!(mem_rdata.next < tqfr_pkg::NIL))
                begin
                    ft_next = mem_rdata.prev;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            hh_reg    <= tqfr_pkg::NIL;
            ht_reg    <= tqfr_pkg::NIL;
            fh_reg    <= tqfr_pkg::NIL;
            ft_reg    <= tqfr_pkg::NIL;
        end
        else
        begin
            state_reg <= state_next;
            hh_reg    <= hh_next;
            ht_reg    <= ht_next;
            fh_reg    <= fh_next;
            ft_reg    <= ft_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        cur_reg  <= cur_next;
        p_reg    <= p_next;
        n_reg    <= n_next;
        old_reg  <= old_next;
        list_reg <= list_next;
        res_reg  <= res_next;
    end

endmodule

// ===== hw/rtl/two_queue_frame_replacer.sv =====
// Top level of the two-queue (2Q) buffer-frame replacer.
//
// Input beats carry an opcode on s_axis_tuser (pin, unpin or victim request) and a
// frame index on s_axis_tdata. Every input beat produces exactly one output beat:
// m_axis_tuser says whether a victim was removed and m_axis_tdata holds its frame.
// Pin and unpin beats always return zero.
// One item is processed at a time through a single-port frame memory with a
// registered read, so the list updates of an item are made one after another.
// A victim request walks the history list from its tail, then the frequent list,
// skipping pinned frames.
// The result sits in an output register, so the next item is accepted while it
// waits; a stalled receiver only holds the block when the following result is ready.
// After reset the block sweeps the tracked bits of all 1024 frames, one per cycle,
// and s_axis_tready stays low until the sweep is done.
module two_queue_frame_replacer (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [tqfr_pkg::TDATA_W-1:0]   s_axis_tdata,  // [9:0] frame
    input  logic [tqfr_pkg::OP_W-1:0]      s_axis_tuser,  // [1:0] opcode
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [tqfr_pkg::TDATA_W-1:0]   m_axis_tdata,  // [9:0] victim_frame
    output logic                           m_axis_tuser   // [0] victim_found
);

    tqfr_pkg::mem_req_t mem_req;
    tqfr_pkg::entry_t   mem_rdata;
    logic               mem_busy;
    logic               res_valid;
    logic               res_ready;
    tqfr_pkg::result_t  res;
    logic               out_valid_reg, out_valid_next;
    tqfr_pkg::result_t  out_reg, out_next;

    tqfr_frame_ram u_ram (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mem_req),
        .rdata (mem_rdata),
        .busy  (mem_busy)
    );

    tqfr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_opcode (s_axis_tuser),
        .in_frame  (s_axis_tdata[tqfr_pkg::FIELD_W-1:0]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata),
        .mem_busy  (mem_busy)
    );

    assign res_ready     = !out_valid_reg || m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = tqfr_pkg::TDATA_W'(out_reg.frame);
    assign m_axis_tuser  = out_reg.found;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted on two consecutive cycles");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready |=> m_axis_tvalid)
        else $error("finished result not presented on the output");

    assert property (@(posedge clk) disable iff (!rst_n)
        mem_busy |-> !s_axis_tready && !res_valid)
        else $error("item handled during the tracked-bit clearing pass");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.found |-> res.frame == '0)
        else $error("nonzero frame reported without a victim");

endmodule

// ===== tb/two_queue_frame_replacer_tb.sv =====
// Self-checking testbench of the two-queue frame replacer: random and directed beats with a predictor.
`timescale 1ns / 1ps

module two_queue_frame_replacer_tb;

    localparam logic [tqfr_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
    localparam bit LIST_HISTORY  = 1'b0;
    localparam bit LIST_FREQUENT = 1'b1;
    localparam int RANDOM_ITEMS  = 900;
    localparam int POOL_SIZE     = 24;
    localparam int TAIL_CYCLES   = 64;
    localparam int LIMIT         = 2000 + tqfr_pkg::FRAMES
                                   + 3 * (RANDOM_ITEMS + 100) * (2 * tqfr_pkg::FRAMES + 100);

    typedef struct {
        logic [tqfr_pkg::OP_W-1:0] op;
        tqfr_pkg::addr_t           frame;
        bit                        hold;
    } beat_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [tqfr_pkg::TDATA_W-1:0]   s_axis_tdata = '0;
    logic [tqfr_pkg::OP_W-1:0]      s_axis_tuser = '0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [tqfr_pkg::TDATA_W-1:0]   m_axis_tdata;
    logic                           m_axis_tuser;

    beat_t             pending_beats[$];
    tqfr_pkg::result_t expected_results[$];
    beat_t             next_beat;
    tqfr_pkg::addr_t   pool[POOL_SIZE];

    bit                tracked_q[tqfr_pkg::FRAMES];
    bit                frequent_q[tqfr_pkg::FRAMES];
    bit                pinned_q[tqfr_pkg::FRAMES];
    tqfr_pkg::node_t   link_next_q[tqfr_pkg::FRAMES];
    tqfr_pkg::node_t   link_prev_q[tqfr_pkg::FRAMES];
    tqfr_pkg::node_t   head_of[2];
    tqfr_pkg::node_t   tail_of[2];

    int      beats_in;
    int      results_out;
    int      total_beats;
    int      mismatches;
    int      victims_hit;
    int      victims_missed;
    int      cycles;
    int      send_gap;
    int      send_mode;
    int      stall_left;
    int      stall_mode;

    two_queue_frame_replacer u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    function automatic void unlink_frame(input tqfr_pkg::addr_t f, input bit which);
        tqfr_pkg::node_t p;
        tqfr_pkg::node_t n;
        p = link_prev_q[f];
        n = link_next_q[f];
        if (p != tqfr_pkg::NIL)
            link_next_q[p[tqfr_pkg::FRAME_W-1:0]] = n;
        else
            head_of[which] = n;
        if (n != tqfr_pkg::NIL)
            link_prev_q[n[tqfr_pkg::FRAME_W-1:0]] = p;
        else
            tail_of[which] = p;
    endfunction

    function automatic void push_to_head(input tqfr_pkg::addr_t f, input bit which);
        tqfr_pkg::node_t old;
        old = head_of[which];
        link_prev_q[f] = tqfr_pkg::NIL;
        link_next_q[f] = old;
        if (old != tqfr_pkg::NIL)
            link_prev_q[old[tqfr_pkg::FRAME_W-1:0]] = tqfr_pkg::node_t'(f);
        else
            tail_of[which] = tqfr_pkg::node_t'(f);
        head_of[which] = tqfr_pkg::node_t'(f);
    endfunction

    function automatic bit evict_oldest_unpinned(input bit which, output tqfr_pkg::addr_t got);
        tqfr_pkg::node_t cur;
        int              steps;
        cur = tail_of[which];
        steps = 0;
        got = '0;
        while (cur != tqfr_pkg::NIL && steps < tqfr_pkg::FRAMES)
        begin
            if (!pinned_q[cur[tqfr_pkg::FRAME_W-1:0]])
            begin
                unlink_frame(cur[tqfr_pkg::FRAME_W-1:0], which);
                tracked_q[cur[tqfr_pkg::FRAME_W-1:0]] = 1'b0;
                got = cur[tqfr_pkg::FRAME_W-1:0];
                return 1'b1;
            end
            cur = link_prev_q[cur[tqfr_pkg::FRAME_W-1:0]];
            steps++;
        end
        return 1'b0;
    endfunction

    function automatic void predict_replacement(input logic [tqfr_pkg::OP_W-1:0] op,
                                                input tqfr_pkg::addr_t f);
        tqfr_pkg::result_t res;
        tqfr_pkg::addr_t   got;
        res = '0;
        if (op == tqfr_pkg::OP_PIN)
        begin
            if (tracked_q[f])
                pinned_q[f] = 1'b1;
        end
        else if (op == tqfr_pkg::OP_UNPIN)
        begin
            if (!tracked_q[f])
            begin
                tracked_q[f] = 1'b1;
                frequent_q[f] = 1'b0;
                push_to_head(f, LIST_HISTORY);
            end
            else
            begin
                unlink_frame(f, frequent_q[f]);
                frequent_q[f] = 1'b1;
                push_to_head(f, LIST_FREQUENT);
            end
            pinned_q[f] = 1'b0;
        end
        else if (op == tqfr_pkg::OP_VICTIM)
        begin
            if (evict_oldest_unpinned(LIST_HISTORY, got) ||
                evict_oldest_unpinned(LIST_FREQUENT, got))
            begin
                res.found = 1'b1;
                res.frame = got;
                victims_hit++;
            end
            else
                victims_missed++;
        end
        expected_results.push_back(res);
    endfunction

    function automatic int pick_gap(input int mode);
        int r;
        if (mode == 0)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    function automatic tqfr_pkg::addr_t pick_frame();
        if ($urandom_range(0, 99) < 85)
            return pool[$urandom_range(0, POOL_SIZE - 1)];
        return tqfr_pkg::addr_t'($urandom_range(0, tqfr_pkg::FRAMES - 1));
    endfunction

    function automatic void add_beat(input logic [tqfr_pkg::OP_W-1:0] op,
                                     input tqfr_pkg::addr_t f, input bit hold);
        beat_t b;
        b.op = op;
        b.frame = f;
        b.hold = hold;
        pending_beats.push_back(b);
    endfunction

    function automatic void note_mismatch(input string what, input tqfr_pkg::result_t want);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] result %0d %s: expected found=%0b frame=%0d, got found=%0b data=%0d",
                     $realtime, results_out, what, want.found, want.frame,
                     m_axis_tuser, m_axis_tdata);
    endfunction

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("two_queue_frame_replacer verification failed");
            $finish;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
            send_gap      <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_replacement(s_axis_tuser, s_axis_tdata[tqfr_pkg::FRAME_W-1:0]);
                beats_in++;
                if (beats_in % 50 == 0)
                    send_mode = $urandom_range(0, 2);
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_beats.size() != 0 &&
                         !(pending_beats[0].hold && expected_results.size() != 0))
                begin
                    next_beat = pending_beats.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= tqfr_pkg::TDATA_W'(next_beat.frame);
                    s_axis_tuser  <= next_beat.op;
                    send_gap      <= pick_gap(send_mode);
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_out++;
                if (results_out % 50 == 0)
                    stall_mode = $urandom_range(0, 2);
                if (expected_results.size() == 0)
                    note_mismatch("with nothing expected", '0);
                else if (m_axis_tuser !== expected_results[0].found ||
                         m_axis_tdata !== tqfr_pkg::TDATA_W'(expected_results[0].frame))
                    note_mismatch("differs", expected_results.pop_front());
                else
                    void'(expected_results.pop_front());
            end
            if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(0, 99) < 30)
                    stall_left <= pick_gap(stall_mode);
            end
        end
    end

    initial
    begin
        int counted;
        int len;
        int n_pins;
        int r;
        tqfr_pkg::addr_t f;
        bit hold;

        head_of = '{tqfr_pkg::NIL, tqfr_pkg::NIL};
        tail_of = '{tqfr_pkg::NIL, tqfr_pkg::NIL};
        send_mode = 0;
        stall_mode = 0;
        foreach (pool[i])
            pool[i] = tqfr_pkg::addr_t'($urandom_range(0, tqfr_pkg::FRAMES - 1));

        // Directed part: ignored pins, empty victims, promotions, pinned skips.
        add_beat(tqfr_pkg::OP_PIN,    10'd5,    1'b0);
        add_beat(tqfr_pkg::OP_VICTIM, 10'd0,    1'b0);
        add_beat(tqfr_pkg::OP_UNPIN,  10'd0,    1'b0);
        add_beat(tqfr_pkg::OP_UNPIN,  10'd1023, 1'b0);
        add_beat(tqfr_pkg::OP_UNPIN,  10'd512,  1'b0);
        add_beat(tqfr_pkg::OP_UNPIN,  10'd0,    1'b0);
        add_beat(tqfr_pkg::OP_UNPIN,  10'd0,    1'b0);
        add_beat(tqfr_pkg::OP_UNPIN,  10'd1023, 1'b0);
        add_beat(tqfr_pkg::OP_PIN,    10'd512,  1'b0);
        add_beat(OP_UNUSED,           10'd1023, 1'b0);
        add_beat(tqfr_pkg::OP_VICTIM, 10'd1023, 1'b0);
        add_beat(tqfr_pkg::OP_PIN,    10'd1023, 1'b0);
        add_beat(tqfr_pkg::OP_VICTIM, 10'd0,    1'b0);
        add_beat(tqfr_pkg::OP_UNPIN,  10'd512,  1'b0);
        add_beat(tqfr_pkg::OP_VICTIM, 10'd0,    1'b0);
        add_beat(tqfr_pkg::OP_UNPIN,  10'd1023, 1'b0);
        add_beat(tqfr_pkg::OP_VICTIM, 10'd0,    1'b0);
        add_beat(tqfr_pkg::OP_VICTIM, 10'd0,    1'b0);
        add_beat(tqfr_pkg::OP_UNPIN,  10'd341,  1'b0);
        add_beat(tqfr_pkg::OP_UNPIN,  10'd682,  1'b0);
        add_beat(tqfr_pkg::OP_PIN,    10'd341,  1'b0);
        add_beat(tqfr_pkg::OP_VICTIM, 10'd0,    1'b0);
        add_beat(tqfr_pkg::OP_VICTIM, 10'd0,    1'b0);
        add_beat(OP_UNUSED,           10'd0,    1'b0);
        add_beat(tqfr_pkg::OP_UNPIN,  10'd341,  1'b0);

        counted = 0;
        hold = 1'b1;
        while (counted < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 9) < 6)
            begin
                for (int i = 0; i < 20; i++)
                begin
                    r = $urandom_range(0, 99);
                    f = pick_frame();
                    if (r < 40)
                        add_beat(tqfr_pkg::OP_UNPIN, f, hold);
                    else if (r < 70)
                        add_beat(tqfr_pkg::OP_PIN, f, hold);
                    else if (r < 95)
                        add_beat(tqfr_pkg::OP_VICTIM, f, hold);
                    else
                        add_beat(OP_UNUSED, f, hold);
                    if (r < 95)
                        counted++;
                    hold = 1'b0;
                end
            end
            else
            begin
                len = $urandom_range(2, 12);
                n_pins = $urandom_range(0, len);
                for (int i = 0; i < len; i++)
                begin
                    add_beat(tqfr_pkg::OP_UNPIN, pick_frame(), hold);
                    hold = 1'b0;
                end
                for (int i = 0; i < n_pins; i++)
                    add_beat(tqfr_pkg::OP_PIN, pick_frame(), 1'b0);
                for (int i = 0; i < len + 2; i++)
                    add_beat(tqfr_pkg::OP_VICTIM,
                             tqfr_pkg::addr_t'($urandom_range(0, tqfr_pkg::FRAMES - 1)), 1'b0);
                counted += 2 * len + n_pins + 2;
            end
            hold = ($urandom_range(0, 9) == 0);
        end
        total_beats = pending_beats.size();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (beats_in != total_beats)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d beats and %0d results: %0d victims removed, %0d requests with none.",
                 beats_in, results_out, victims_hit, victims_missed);
        if (mismatches == 0)
            $display("two_queue_frame_replacer verification clean");
        else
            $display("two_queue_frame_replacer verification failed");
        $finish;
    end

endmodule
